FILE: hdl/pvd_pkg.sv
package pvd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // register reset values
    localparam logic [15:0] RST_GAIN_P         = 16'd26214;
    localparam logic [15:0] RST_GAIN_I         = 16'd1311;
    localparam logic [15:0] RST_GAIN_D         = 16'd2621;
    localparam logic [11:0] RST_TOLERANCE      = 12'd64;
    localparam logic [22:0] RST_INTEGRAL_LIMIT = 23'd4800000;
    localparam logic [15:0] RST_RATE_LIMIT     = 16'd4800;
    localparam logic [15:0] RST_DRIVE_LIMIT    = 16'd4800;
    localparam logic [19:0] RST_FIRST_PAD_MS   = 20'd300000;

    // divider divisor width: elapsed ms plus first-step pad
    localparam int DIV_W = 21;
    // ms per second; also the integral term's scale
    localparam logic [DIV_W-1:0] MS_PER_S = 21'd1000;
    // Q0.16 gains
    localparam int GAIN_FRAC = 16;
    // integral state width
    localparam int INTEG_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_TOLERANCE      = 3'd3,
        CFG_INTEGRAL_LIMIT = 3'd4,
        CFG_RATE_LIMIT     = 3'd5,
        CFG_DRIVE_LIMIT    = 3'd6,
        CFG_FIRST_PAD_MS   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_ADD     = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_HOLD    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MUL_ERR_MS = 2'd0,
        MUL_P      = 2'd1,
        MUL_D      = 2'd2,
        MUL_I      = 2'd3
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_I,
        ST_INT,
        ST_ACC_P,
        ST_DIV_D,
        ST_MUL_D,
        ST_ACC_D,
        ST_SCALE,
        ST_ACC_I,
        ST_OUT,
        ST_WAIT_Q,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [11:0] tolerance;
        logic [22:0] integral_limit;
        logic [15:0] rate_limit;
        logic [15:0] drive_limit;
        logic [19:0] first_pad_ms;
    } t_cfg;

    typedef struct packed {
        logic     load;      // capture input item, form error
        t_mul_sel mul_sel;
        logic     prod_en;   // register multiplier product
        logic     der_prep;  // form |delta|*1000 and divisor
        logic     int_upd;   // update integral, start derivative divide
        logic     acc_load;
        logic     acc_add;
        logic     acc_scale; // acc *= 1000
        logic     d_cap;     // capture clamped derivative
        logic     out_prep;  // deadband compare, start output divide
        logic     commit;    // hand result over, update state
    } t_cmd;

    typedef struct packed {
        logic in_band;
        logic div_busy;
    } t_status;

endpackage

FILE: hdl/pvd_div.sv
module pvd_div #(
    parameter int NUM_W = 30
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [NUM_W-1:0]          i_num,
    input  logic [pvd_pkg::DIV_W-1:0] i_den,
    output logic                      o_busy,
    output logic [NUM_W-1:0]          o_quot
);
    import pvd_pkg::*;

    // restoring division, two quotient bits per cycle
    localparam int STEPS = NUM_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_den;

    logic [NUM_W-1:0] n_q;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W:0]   w_t;
    logic             w_ge;

    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        w_t   = '0;
        w_ge  = 1'b0;
        for (int k = 0; k < 2; k++) begin
            w_t   = {n_rem, n_q[NUM_W-1]};
            w_ge  = (w_t >= {1'b0, r_den});
            n_q   = {n_q[NUM_W-2:0], w_ge};
            n_rem = w_ge ? DIV_W'(w_t - {1'b0, r_den}) : w_t[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

FILE: hdl/pvd_datapath.sv
module pvd_datapath #(
    parameter int ANGLE_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pvd_pkg::t_cmd                 i_cmd,
    input  pvd_pkg::t_cfg                 i_cfg,
    input  logic                          i_start_run,
    input  logic signed [ANGLE_BITS-1:0]  i_target_angle,
    input  logic signed [ANGLE_BITS-1:0]  i_measured_angle,
    input  logic [15:0]                   i_elapsed_ms,
    output pvd_pkg::t_status              o_status,
    output pvd_pkg::t_action              o_action,
    output logic [15:0]                   o_drive_magnitude,
    output logic signed [ANGLE_BITS:0]    o_error_value
);
    import pvd_pkg::*;

    localparam int ERR_W = ANGLE_BITS + 1;
    localparam int MA_W  = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;
    localparam int MB_W  = 17;
    localparam int PW    = MA_W + MB_W;
    // P and D terms, +1 for their sum, +10 for *1000, +1 for the I term
    localparam int SW    = ((ERR_W + 17 > 34) ? ERR_W + 17 : 34) + 12;
    localparam int DN_W  = ERR_W + 11;
    localparam int NR    = (DN_W > SW - 16) ? DN_W : SW - 16;
    localparam int N_W   = NR + (NR % 2);
    localparam int TOLS_W = 12 + 10 + GAIN_FRAC;

    logic signed [ERR_W-1:0]   r_err;
    logic [15:0]               r_ms;
    logic signed [INTEG_W-1:0] r_integral;
    logic signed [ERR_W-1:0]   r_last;
    logic                      r_first;
    logic signed [PW-1:0]      r_prod;
    logic signed [SW-1:0]      r_acc;
    logic [N_W-1:0]            r_dnum;
    logic [DIV_W-1:0]          r_dden;
    logic                      r_dneg;
    logic                      r_dzero;
    logic                      r_divz;
    logic signed [16:0]        r_d;
    logic                      r_over;
    logic                      r_pos;

    logic [ERR_W-1:0]          w_abs_err;
    logic signed [ERR_W:0]     w_delta;
    logic [ERR_W:0]            w_abs_delta;
    logic [DN_W-1:0]           w_dx;
    logic [DN_W-1:0]           w_dx1000;
    logic [DIV_W-1:0]          w_dden;
    logic signed [MA_W-1:0]    w_ma;
    logic signed [MB_W-1:0]    w_mb;
    logic signed [PW-1:0]      w_prod;
    logic signed [PW:0]        w_isum;
    logic signed [PW:0]        w_ilim;
    logic signed [INTEG_W-1:0] w_integ_next;
    logic signed [SW-1:0]      w_prod_ext;
    logic [SW-1:0]             w_acc_abs;
    logic [21:0]               w_tol1000;
    logic [TOLS_W-1:0]         w_tols;
    logic [N_W-1:0]            w_quot;
    logic                      w_div_busy;
    logic                      w_div_start;
    logic [N_W-1:0]            w_div_num;
    logic [DIV_W-1:0]          w_div_den;
    logic [15:0]               w_dmag;

    // error deadband
    assign w_abs_err = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
    assign o_status.in_band  = (w_abs_err <= ERR_W'(i_cfg.tolerance));
    assign o_status.div_busy = w_div_busy;

    // derivative numerator |delta| * 1000 and divisor
    assign w_delta     = {r_err[ERR_W-1], r_err} - {r_last[ERR_W-1], r_last};
    assign w_abs_delta = w_delta[ERR_W] ? (ERR_W+1)'(-w_delta) : (ERR_W+1)'(w_delta);
    assign w_dx        = DN_W'(w_abs_delta);
    assign w_dx1000    = (w_dx << 10) - (w_dx << 4) - (w_dx << 3);
    assign w_dden      = DIV_W'(r_ms) + (r_first ? DIV_W'(i_cfg.first_pad_ms) : '0);

    // shared multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_ERR_MS: begin
                w_ma = MA_W'(r_err);
                w_mb = {1'b0, r_ms};
            end
            MUL_P: begin
                w_ma = MA_W'(r_err);
                w_mb = {1'b0, i_cfg.gain_p};
            end
            MUL_D: begin
                w_ma = MA_W'(r_d);
                w_mb = {1'b0, i_cfg.gain_d};
            end
            MUL_I: begin
                w_ma = MA_W'(r_integral);
                w_mb = {1'b0, i_cfg.gain_i};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // integral with symmetric clamp
    assign w_isum = (PW+1)'(r_integral) + (PW+1)'(r_prod);
    assign w_ilim = (PW+1)'({1'b0, i_cfg.integral_limit});

    always_comb begin
        if (w_isum > w_ilim) begin
            w_integ_next = INTEG_W'(w_ilim);
        end else if (w_isum < -w_ilim) begin
            w_integ_next = INTEG_W'(-w_ilim);
        end else begin
            w_integ_next = INTEG_W'(w_isum);
        end
    end

    assign w_prod_ext = SW'(r_prod);

    // output deadband: |S| > tolerance * 65536000
    assign w_acc_abs = r_acc[SW-1] ? SW'(-r_acc) : SW'(r_acc);
    assign w_tol1000 = (22'(i_cfg.tolerance) << 10) - (22'(i_cfg.tolerance) << 4)
                     - (22'(i_cfg.tolerance) << 3);
    assign w_tols    = {w_tol1000, {GAIN_FRAC{1'b0}}};

    // clamped derivative magnitude
    always_comb begin
        if (r_dzero) begin
            w_dmag = '0;
        end else if (r_divz || (w_quot > N_W'(i_cfg.rate_limit))) begin
            w_dmag = i_cfg.rate_limit;
        end else begin
            w_dmag = w_quot[15:0];
        end
    end

    // divider shared between derivative and output scaling
    assign w_div_start = i_cmd.int_upd || i_cmd.out_prep;
    assign w_div_num   = i_cmd.out_prep ? N_W'(w_acc_abs[SW-1:GAIN_FRAC]) : r_dnum;
    assign w_div_den   = i_cmd.out_prep ? MS_PER_S : r_dden;

    pvd_div #(
        .NUM_W (N_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_last     <= '0;
            r_first    <= 1'b1;
        end else if (i_cmd.load) begin
            if (i_start_run) begin
                r_integral <= '0;
                r_last     <= '0;
                r_first    <= 1'b1;
            end
        end else if (i_cmd.int_upd) begin
            r_integral <= w_integ_next;
        end else if (i_cmd.commit) begin
            r_last  <= r_err;
            r_first <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err <= {i_target_angle[ANGLE_BITS-1], i_target_angle}
                   - {i_measured_angle[ANGLE_BITS-1], i_measured_angle};
            r_ms  <= i_elapsed_ms;
        end
        if (i_cmd.prod_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.der_prep) begin
            r_dnum  <= N_W'(w_dx1000);
            r_dden  <= w_dden;
            r_dneg  <= w_delta[ERR_W];
            r_dzero <= (w_delta == '0);
            r_divz  <= (w_dden == '0);
        end
        if (i_cmd.d_cap) begin
            r_d <= r_dneg ? -{1'b0, w_dmag} : {1'b0, w_dmag};
        end
        if (i_cmd.acc_load) begin
            r_acc <= w_prod_ext;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + w_prod_ext;
        end else if (i_cmd.acc_scale) begin
            r_acc <= (r_acc <<< 10) - (r_acc <<< 4) - (r_acc <<< 3);
        end
        if (i_cmd.out_prep) begin
            r_over <= (w_acc_abs > SW'(w_tols));
            r_pos  <= !r_acc[SW-1];
        end
    end

    // result
    always_comb begin
        if (o_status.in_band || r_first) begin
            o_action          = ACT_NONE;
            o_drive_magnitude = '0;
        end else if (!r_over) begin
            o_action          = ACT_HOLD;
            o_drive_magnitude = '0;
        end else begin
            o_action          = r_pos ? ACT_ADD : ACT_RELEASE;
            o_drive_magnitude = (w_quot > N_W'(i_cfg.drive_limit)) ?
                                i_cfg.drive_limit : w_quot[15:0];
        end
    end

    assign o_error_value = r_err;

endmodule

FILE: hdl/pvd_ctrl.sv
module pvd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_free,
    input  pvd_pkg::t_status i_status,
    output logic             o_in_ready,
    output pvd_pkg::t_cmd    o_cmd
);
    import pvd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_CHECK;
            ST_CHECK:  n_state = i_status.in_band ? ST_FINISH : ST_MUL_I;
            ST_MUL_I:  n_state = ST_INT;
            ST_INT:    n_state = ST_ACC_P;
            ST_ACC_P:  n_state = ST_DIV_D;
            ST_DIV_D:  if (!i_status.div_busy) n_state = ST_MUL_D;
            ST_MUL_D:  n_state = ST_ACC_D;
            ST_ACC_D:  n_state = ST_SCALE;
            ST_SCALE:  n_state = ST_ACC_I;
            ST_ACC_I:  n_state = ST_OUT;
            ST_OUT:    n_state = ST_WAIT_Q;
            ST_WAIT_Q: if (!i_status.div_busy) n_state = ST_FINISH;
            ST_FINISH: if (i_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MUL_I: begin
                o_cmd.mul_sel  = MUL_ERR_MS;
                o_cmd.prod_en  = 1'b1;
                o_cmd.der_prep = 1'b1;
            end
            ST_INT: begin
                o_cmd.int_upd = 1'b1;
                o_cmd.mul_sel = MUL_P;
                o_cmd.prod_en = 1'b1;
            end
            ST_ACC_P: o_cmd.acc_load = 1'b1;
            ST_DIV_D: o_cmd.d_cap = !i_status.div_busy;
            ST_MUL_D: begin
                o_cmd.mul_sel = MUL_D;
                o_cmd.prod_en = 1'b1;
            end
            ST_ACC_D: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.mul_sel = MUL_I;
                o_cmd.prod_en = 1'b1;
            end
            ST_SCALE:  o_cmd.acc_scale = 1'b1;
            ST_ACC_I:  o_cmd.acc_add = 1'b1;
            ST_OUT:    o_cmd.out_prep = 1'b1;
            ST_FINISH: o_cmd.commit = i_out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: hdl/pid_valve_drive_controller.sv
// An error inside the deadband goes from input transfer straight to the result; any other
//   error passes the multiply, integral, derivative divide, accumulate and output divide steps.
// Throughput: one item at a time; the serial divider (two quotient bits per cycle) runs twice
//   per item outside the deadband, once for the derivative and once to scale the output.
// Reset: synchronous, active low; configuration registers return to their defaults, the
//   integral and previous error clear and the next step is treated as the first.
module pid_valve_drive_controller #(
    parameter int ANGLE_BITS = 14
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration writes
    input  logic                                   i_cfg_wr_en,
    input  logic [pvd_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [pvd_pkg::CFG_DATA_W-1:0]         i_cfg_wdata,
    // control tick in
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // target_angle, measured_angle, elapsed_ms (lowest bits first), zero padded
    input  logic [((2*ANGLE_BITS+16+7)/8)*8-1:0]   s_axis_tdata,
    // start_run
    input  logic                                   s_axis_tuser,
    // valve command out
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // drive_magnitude, error_value (lowest bits first), zero padded
    output logic [((16+ANGLE_BITS+1+7)/8)*8-1:0]   m_axis_tdata,
    // action
    output logic [1:0]                             m_axis_tuser
);
    import pvd_pkg::*;

    localparam int OUT_DATA_W = ((16 + ANGLE_BITS + 1 + 7) / 8) * 8;

    t_cfg    r_cfg;
    t_cmd    w_cmd;
    t_status w_status;
    t_action w_action;
    logic [15:0]                w_mag;
    logic signed [ANGLE_BITS:0] w_err;
    logic                       w_out_free;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [1:0]            r_m_user;

    // configuration registers; writes must arrive only while idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= RST_GAIN_P;
            r_cfg.gain_i         <= RST_GAIN_I;
            r_cfg.gain_d         <= RST_GAIN_D;
            r_cfg.tolerance      <= RST_TOLERANCE;
            r_cfg.integral_limit <= RST_INTEGRAL_LIMIT;
            r_cfg.rate_limit     <= RST_RATE_LIMIT;
            r_cfg.drive_limit    <= RST_DRIVE_LIMIT;
            r_cfg.first_pad_ms   <= RST_FIRST_PAD_MS;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P:         r_cfg.gain_p         <= i_cfg_wdata[15:0];
                CFG_GAIN_I:         r_cfg.gain_i         <= i_cfg_wdata[15:0];
                CFG_GAIN_D:         r_cfg.gain_d         <= i_cfg_wdata[15:0];
                CFG_TOLERANCE:      r_cfg.tolerance      <= i_cfg_wdata[11:0];
                CFG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_wdata[22:0];
                CFG_RATE_LIMIT:     r_cfg.rate_limit     <= i_cfg_wdata[15:0];
                CFG_DRIVE_LIMIT:    r_cfg.drive_limit    <= i_cfg_wdata[15:0];
                CFG_FIRST_PAD_MS:   r_cfg.first_pad_ms   <= i_cfg_wdata[19:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // result slot may be refilled in the same cycle as its transfer
    assign w_out_free = !r_m_valid || m_axis_tready;

    pvd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    pvd_datapath #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cfg             (r_cfg),
        .i_start_run       (s_axis_tuser),
        .i_target_angle    (s_axis_tdata[ANGLE_BITS-1:0]),
        .i_measured_angle  (s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
        .i_elapsed_ms      (s_axis_tdata[2*ANGLE_BITS+15:2*ANGLE_BITS]),
        .o_status          (w_status),
        .o_action          (w_action),
        .o_drive_magnitude (w_mag),
        .o_error_value     (w_err)
    );

    // output register: frees the core for the next tick while the result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_cmd.commit) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.commit) begin
            r_m_data <= OUT_DATA_W'({w_err, w_mag});
            r_m_user <= w_action;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

FILE: hdl/pvd_checker.sv
module pvd_checker #(
    parameter int ANGLE_BITS = 14
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [((16+ANGLE_BITS+1+7)/8)*8-1:0] m_axis_tdata,
    input logic [1:0]                           m_axis_tuser
);
    import pvd_pkg::*;

    // a held result is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one tick in flight: no transfer straight after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // no-change and hold carry no drive time
    a_idle_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ACT_NONE || m_axis_tuser == ACT_HOLD)
        |-> m_axis_tdata[15:0] == 16'd0)
        else $error("drive magnitude on idle action");

    // reset empties the result slot
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind pid_valve_drive_controller pvd_checker #(
    .ANGLE_BITS (ANGLE_BITS)
) u_pvd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
